/* rtl/core/utf8p_pkg.sv */
// Package for the UTF-8 prober: state codes, lookup tables and table access functions.
package utf8p_pkg;

  localparam int unsigned STATE_W = 4;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CONF_W  = 16;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CONF_W-1:0]  conf_t;

  localparam state_t ST_START = 4'd0;
  localparam state_t ST_ERROR = 4'd1;
  localparam state_t ST_FOUND = 4'd2;

  localparam len_t   MIN_LEN_RESET = 3'd3;
  localparam count_t COUNT_MAX     = 8'd255;
  localparam count_t CONF_STEPS    = 8'd6;

  // eight 4-bit classes per word, lowest byte in the low nibble
  localparam logic [31:0] BYTE_CLASS_TBL [32] = '{
    32'h11111111, 32'h00111111, 32'h11111111, 32'h11110111,
    32'h11111111, 32'h11111111, 32'h11111111, 32'h11111111,
    32'h11111111, 32'h11111111, 32'h11111111, 32'h11111111,
    32'h11111111, 32'h11111111, 32'h11111111, 32'h11111111,
    32'h33332222, 32'h44444444, 32'h44444444, 32'h44444444,
    32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
    32'h66666600, 32'h66666666, 32'h66666666, 32'h66666666,
    32'h88888887, 32'h88988888, 32'hBBBBBBBA, 32'h00FEDDDC
  };

  // next state at index state*16 + class; states 13..15 behave as error
  localparam logic [31:0] TRANS_TBL [32] = '{
    32'hAC111101, 32'h345678B9,
    32'h11111111, 32'h11111111,
    32'h22222222, 32'h22222222,
    32'h11555511, 32'h11111111,
    32'h11555111, 32'h11111111,
    32'h11777711, 32'h11111111,
    32'h11771111, 32'h11111111,
    32'h11999911, 32'h11111111,
    32'h11911111, 32'h11111111,
    32'h11CCCC11, 32'h11111111,
    32'h11C11111, 32'h11111111,
    32'h111CCC11, 32'h11111111,
    32'h11000011, 32'h11111111,
    32'h11111111, 32'h11111111,
    32'h11111111, 32'h11111111,
    32'h11111111, 32'h11111111
  };

  localparam len_t LEAD_LEN_TBL [16] = '{
    3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd3,
    3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6
  };

  // round(65536 * (1 - 0.99 * 2^-n)) for n = 0..5, then round(65536 * 0.99)
  localparam conf_t CONF_TBL [7] = '{
    16'd655, 16'd33096, 16'd49316, 16'd57426, 16'd61481, 16'd63508, 16'd64881
  };

  function automatic class_t lookup_class(input logic [7:0] b);
    logic [31:0] w;
    w = BYTE_CLASS_TBL[b[7:3]];
    return w[{b[2:0], 2'b00} +: CLASS_W];
  endfunction

  function automatic state_t lookup_next(input state_t st, input class_t cls);
    logic [7:0]  idx;
    logic [31:0] w;
    idx = {st, cls};
    w   = TRANS_TBL[idx[7:3]];
    return w[{idx[2:0], 2'b00} +: STATE_W];
  endfunction

  function automatic conf_t confidence_of(input count_t cnt);
    logic [2:0] n;
    n = (cnt >= CONF_STEPS) ? CONF_STEPS[2:0] : cnt[2:0];
    return CONF_TBL[n];
  endfunction

endpackage

/* rtl/core/utf8_charset_prober_core.sv */
// UTF-8 charset prober: one byte per cycle unless stalled; class table, FSM and count.
//
// Takes one byte per cycle, sustained while out_stall is low: the byte is captured
// in an input register, and the class lookup, transition lookup, length select and
// count update run combinationally into the result register. That logic closes the
// loop through the coder state, length and count registers, which is what sets the
// one-byte-per-cycle figure. A result waiting on out_stall does not hold up the input
// register until both stages are full. min_counted_len is written over the always-ready
// cfg port; the user must write it only while no bytes are in flight (not enforced).
module utf8_charset_prober_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_first_of_buffer,
  input  logic                      in_last_of_buffer,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_prober_state,
  output logic [2:0]                out_seq_len,
  output logic [7:0]                out_multibyte_count,
  output logic [15:0]               out_confidence,
  output logic                      out_is_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_min_counted_len
);

  // input stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic        s1_last_r;

  // prober state
  utf8p_pkg::state_t state_r, state_nxt;
  utf8p_pkg::len_t   len_r, len_nxt;
  utf8p_pkg::count_t count_r, count_nxt;
  utf8p_pkg::len_t   min_len_r;

  // result register
  logic              res_valid_r;
  utf8p_pkg::state_t res_state_r;
  utf8p_pkg::len_t   res_len_r;
  utf8p_pkg::count_t res_count_r;
  utf8p_pkg::conf_t  res_conf_r, conf_nxt;
  logic              res_last_r;

  logic              res_free;
  logic              s1_fire;
  logic              in_fire;
  utf8p_pkg::class_t cls;
  utf8p_pkg::count_t count_base;
  logic              count_inc;

  assign res_free  = !res_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && res_free;
  assign in_stall  = s1_valid_r && !res_free;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    cls        = utf8p_pkg::lookup_class(s1_byte_r);
    count_base = s1_first_r ? '0 : count_r;
    len_nxt    = (state_r == utf8p_pkg::ST_START) ? utf8p_pkg::LEAD_LEN_TBL[cls] : len_r;
    state_nxt  = utf8p_pkg::lookup_next(state_r, cls);
    count_inc  = (state_nxt == utf8p_pkg::ST_START) && (len_nxt >= min_len_r) &&
                 (count_base != utf8p_pkg::COUNT_MAX);
    count_nxt  = count_base + {7'd0, count_inc};
    conf_nxt   = (s1_last_r && state_nxt != utf8p_pkg::ST_FOUND) ?
                 utf8p_pkg::confidence_of(count_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      state_r     <= utf8p_pkg::ST_START;
      len_r       <= '0;
      count_r     <= '0;
      min_len_r   <= utf8p_pkg::MIN_LEN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_len_r <= cfg_min_counted_len;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        res_valid_r <= 1'b1;
        state_r     <= state_nxt;
        len_r       <= len_nxt;
        count_r     <= count_nxt;
      end else if (!out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first_of_buffer;
      s1_last_r  <= in_last_of_buffer;
    end
    if (s1_fire) begin
      res_state_r <= state_nxt;
      res_len_r   <= len_nxt;
      res_count_r <= count_nxt;
      res_conf_r  <= conf_nxt;
      res_last_r  <= s1_last_r;
    end
  end

  assign out_valid           = res_valid_r;
  assign out_prober_state    = res_state_r;
  assign out_seq_len         = res_len_r;
  assign out_multibyte_count = res_count_r;
  assign out_confidence      = res_conf_r;
  assign out_is_last         = res_last_r;

endmodule

/* rtl/core/utf8p_checker.sv */
// Port-level checker for the UTF-8 prober, bound to the prober core.
module utf8p_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_prober_state,
  input logic [2:0]  out_seq_len,
  input logic [7:0]  out_multibyte_count,
  input logic [15:0] out_confidence,
  input logic        out_is_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prober_state) &&
      $stable(out_seq_len) && $stable(out_multibyte_count) &&
      $stable(out_confidence) && $stable(out_is_last))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_conf_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_confidence == 16'd0)
    else $error("confidence on a word that does not close a buffer");

  a_found_no_conf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prober_state == utf8p_pkg::ST_FOUND |-> out_confidence == 16'd0)
    else $error("confidence given in found state");

  a_last_has_conf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last && out_prober_state != utf8p_pkg::ST_FOUND
      |-> out_confidence != 16'd0)
    else $error("missing confidence on closing word");

endmodule

bind utf8_charset_prober_core utf8p_checker u_utf8p_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_prober_state    (out_prober_state),
  .out_seq_len         (out_seq_len),
  .out_multibyte_count (out_multibyte_count),
  .out_confidence      (out_confidence),
  .out_is_last         (out_is_last)
);
